FILE: src/command_line_tokenizer_core_assert.svh
// Assertion macros for the command line tokenizer.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef COMMAND_LINE_TOKENIZER_CORE_ASSERT_SVH
`define COMMAND_LINE_TOKENIZER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, disabled while reset is asserted
`define CLT_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("clt check failed");
// next-cycle implication, disabled while reset is asserted
`define CLT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("clt check failed");
`else
`define CLT_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define CLT_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/clt_pkg.sv
// Shared types and constants for the command line tokenizer.
// No dependencies.
`timescale 1ns / 1ps

package clt_pkg;

    localparam logic [7:0] SPACE_CHAR = 8'd32;
    localparam logic [7:0] NUL_CHAR   = 8'd0;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // one result beat
    typedef struct packed {
        logic       kind;
        logic [2:0] arg_index;
        logic [4:0] char_pos;
        logic [7:0] char_value;
        logic [3:0] arg_count;
        logic       truncated;
    } t_result;

endpackage

FILE: src/clt_step.sv
// Per-character tokenizer step: next state and optional result beat.
// Depends on clt_pkg.
`timescale 1ns / 1ps

module clt_step
    import clt_pkg::*;
#(
    parameter int MAX_ARGS     = 8,
    parameter int ARG_CAPACITY = 32,
    parameter int AW           = 4,
    parameter int LW           = 5
) (
    input  logic [7:0]    i_ch,
    input  logic          i_end_of_line,
    input  logic [AW-1:0] i_args,
    input  logic          i_inside,
    input  logic [LW-1:0] i_len,
    input  logic          i_lost,
    output logic [AW-1:0] o_args,
    output logic          o_inside,
    output logic [LW-1:0] o_len,
    output logic          o_lost,
    output logic          o_res_valid,
    output t_result       o_res
);

    localparam logic [AW-1:0] ARGS_MAX = AW'(MAX_ARGS);
    localparam logic [LW:0]   CAP      = (LW+1)'(ARG_CAPACITY);

    logic          store;
    logic [LW-1:0] len_cur;
    logic [31:0]   pos_w;
    logic [31:0]   idx_w;
    logic [31:0]   cnt_w;

    always_comb begin
        o_args      = i_args;
        o_inside    = i_inside;
        o_len       = i_len;
        o_lost      = i_lost;
        o_res_valid = 1'b0;
        o_res       = '0;
        store       = 1'b0;
        len_cur     = i_len;
        cnt_w       = 32'(i_args);
        pos_w       = '0;
        idx_w       = '0;

        if (i_end_of_line) begin
            o_res_valid     = 1'b1;
            o_res.kind      = KIND_SUMMARY;
            o_res.arg_count = cnt_w[3:0];
            o_res.truncated = i_lost;
            o_args          = '0;
            o_inside        = 1'b0;
            o_len           = '0;
            o_lost          = 1'b0;
        end else if (i_ch != NUL_CHAR) begin
            if (!i_inside) begin
                if (i_ch != SPACE_CHAR && i_args < ARGS_MAX) begin
                    // new argument begins
                    o_args   = i_args + AW'(1);
                    o_inside = 1'b1;
                    len_cur  = '0;
                    store    = 1'b1;
                end
            end else if (i_ch == SPACE_CHAR && i_args < ARGS_MAX) begin
                o_inside = 1'b0;
            end else begin
                store = 1'b1;
            end

            if (store) begin
                if (({1'b0, len_cur} + (LW+1)'(1)) < CAP) begin
                    pos_w            = 32'(len_cur);
                    idx_w            = 32'(o_args) - 32'd1;
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_CHAR;
                    o_res.arg_index  = idx_w[2:0];
                    o_res.char_pos   = pos_w[4:0];
                    o_res.char_value = i_ch;
                    o_len            = len_cur + LW'(1);
                end else begin
                    o_len  = len_cur;
                    o_lost = 1'b1;
                end
            end
        end
    end

endmodule

FILE: src/command_line_tokenizer_core.sv
// Command line tokenizer top level: input register, step logic, result register.
// Depends on clt_pkg, clt_step and command_line_tokenizer_core_assert.svh.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------
//   in      | to core   | i_in_valid / o_in_stall | i_ch, i_end_of_line
//   out     | from core | o_out_valid/i_out_stall | o_kind .. o_truncated
//
// One beat per cycle sustained unless the output stalls; a beat passes the input
// register, then the result register. The tokenizer state updates in the same cycle
// that a beat leaves the input register, so the next character sees it directly.
// Reset is synchronous and active low; it clears state and both valid flags.
// o_in_stall rises only when the input register holds a beat and the result
// register is full and stalled downstream.
`timescale 1ns / 1ps
`include "command_line_tokenizer_core_assert.svh"

module command_line_tokenizer_core
    import clt_pkg::*;
#(
    parameter int MAX_ARGS     = 8,
    parameter int ARG_CAPACITY = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_ch,
    input  logic       i_end_of_line,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_kind,
    output logic [2:0] o_arg_index,
    output logic [4:0] o_char_pos,
    output logic [7:0] o_char_value,
    output logic [3:0] o_arg_count,
    output logic       o_truncated
);

    // r_args must hold MAX_ARGS itself; token length tops out at ARG_CAPACITY-1
    localparam int AW = $clog2(MAX_ARGS + 1);
    localparam int LW = $clog2(ARG_CAPACITY);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       r_in_eol;

    // tokenizer state
    logic [AW-1:0] r_args,   n_args;
    logic          r_inside, n_inside;
    logic [LW-1:0] r_len,    n_len;
    logic          r_lost,   n_lost;

    // result register
    logic    r_out_valid;
    t_result r_out;

    logic    res_valid;
    t_result res;
    logic    advance;
    logic    in_accept;

    // the result stage moves when it is empty or its beat is being taken
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    clt_step #(
        .MAX_ARGS     (MAX_ARGS),
        .ARG_CAPACITY (ARG_CAPACITY),
        .AW           (AW),
        .LW           (LW)
    ) u_step (
        .i_ch          (r_in_ch),
        .i_end_of_line (r_in_eol),
        .i_args        (r_args),
        .i_inside      (r_inside),
        .i_len         (r_len),
        .i_lost        (r_lost),
        .o_args        (n_args),
        .o_inside      (n_inside),
        .o_len         (n_len),
        .o_lost        (n_lost),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    // input register: load on accept, drain when the step consumes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_ch  <= i_ch;
            r_in_eol <= i_end_of_line;
        end
    end

    // state and result update together when a beat passes through the step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_args      <= '0;
            r_inside    <= 1'b0;
            r_len       <= '0;
            r_lost      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && res_valid;
            if (r_in_valid) begin
                r_args   <= n_args;
                r_inside <= n_inside;
                r_len    <= n_len;
                r_lost   <= n_lost;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_out.kind;
    assign o_arg_index  = r_out.arg_index;
    assign o_char_pos   = r_out.char_pos;
    assign o_char_value = r_out.char_value;
    assign o_arg_count  = r_out.arg_count;
    assign o_truncated  = r_out.truncated;

    // checks
    `CLT_ASSERT_NOW(a_args_bound, i_clk, i_rst_n, 1'b1, r_args <= AW'(MAX_ARGS))
    `CLT_ASSERT_NOW(a_len_bound, i_clk, i_rst_n, 1'b1, ({1'b0, r_len} < (LW+1)'(ARG_CAPACITY)))
    `CLT_ASSERT_NOW(a_inside_has_arg, i_clk, i_rst_n, r_inside, r_args != '0)
    `CLT_ASSERT_NEXT(a_eol_clears, i_clk, i_rst_n, advance && r_in_valid && r_in_eol, r_args == '0 && !r_inside && !r_lost && r_out_valid)
    `CLT_ASSERT_NOW(a_summary_fields, i_clk, i_rst_n, r_out_valid && r_out.kind == KIND_SUMMARY, r_out.char_value == NUL_CHAR && r_out.char_pos == '0)

endmodule

FILE: test/clt_token_checker.sv
// Checker for the command line tokenizer: tracks the line state, predicts each result beat
// and compares it with what leaves the core. Depends on clt_pkg.
`timescale 1ns / 1ps

module clt_token_checker
    import clt_pkg::*;
#(
    parameter int MAX_ARGS     = 8,
    parameter int ARG_CAPACITY = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_ch,
    input  logic       i_end_of_line,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_kind,
    input  logic [2:0] i_arg_index,
    input  logic [4:0] i_char_pos,
    input  logic [7:0] i_char_value,
    input  logic [3:0] i_arg_count,
    input  logic       i_truncated,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_beats_checked,
    output int         o_full_lines,
    output int         o_truncated_lines
);

    // line state
    int line_args;
    bit in_arg;
    int arg_len;
    bit line_truncated;

    t_result token_beats_due[$];
    int      fail_count;
    int      beats_checked;
    int      full_lines;
    int      truncated_lines;

    initial begin
        fail_count      = 0;
        beats_checked   = 0;
        full_lines      = 0;
        truncated_lines = 0;
    end

    function automatic void clear_line();
        line_args      = 0;
        in_arg         = 1'b0;
        arg_len        = 0;
        line_truncated = 1'b0;
    endfunction

    // returns 1 when the character (or end of line) yields a result beat
    function automatic bit tokenize_char(input logic [7:0] c, input logic eol,
                                         output t_result beat);
        beat = '0;
        if (eol) begin
            beat.kind      = KIND_SUMMARY;
            beat.arg_count = 4'(line_args);
            beat.truncated = line_truncated;
            clear_line();
            return 1'b1;
        end
        if (c == NUL_CHAR)
            return 1'b0;
        if (!in_arg) begin
            if (c == SPACE_CHAR || line_args >= MAX_ARGS)
                return 1'b0;
            line_args++;
            in_arg  = 1'b1;
            arg_len = 0;
        end else if (c == SPACE_CHAR && line_args < MAX_ARGS) begin
            in_arg = 1'b0;
            return 1'b0;
        end
        if (arg_len + 1 < ARG_CAPACITY) begin
            beat.kind       = KIND_CHAR;
            beat.arg_index  = 3'(line_args - 1);
            beat.char_pos   = 5'(arg_len);
            beat.char_value = c;
            arg_len++;
            return 1'b1;
        end
        line_truncated = 1'b1;
        return 1'b0;
    endfunction

    function automatic bit field_differs(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result due;
        t_result seen;
        t_result produced;
        bit      wrong;
        if (!i_rst_n) begin
            clear_line();
            token_beats_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                seen = {i_kind, i_arg_index, i_char_pos, i_char_value, i_arg_count,
                        i_truncated};
                if (token_beats_due.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    fail_count++;
                end else begin
                    due   = token_beats_due.pop_front();
                    wrong = 1'b0;
                    wrong |= field_differs("kind", due.kind, seen.kind);
                    wrong |= field_differs("arg_index", due.arg_index, seen.arg_index);
                    wrong |= field_differs("char_pos", due.char_pos, seen.char_pos);
                    wrong |= field_differs("char_value", due.char_value, seen.char_value);
                    wrong |= field_differs("arg_count", due.arg_count, seen.arg_count);
                    wrong |= field_differs("truncated", due.truncated, seen.truncated);
                    if (wrong)
                        fail_count++;
                    beats_checked++;
                    if (due.kind == KIND_SUMMARY) begin
                        if (due.arg_count == 4'(MAX_ARGS))
                            full_lines++;
                        if (due.truncated)
                            truncated_lines++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (tokenize_char(i_ch, i_end_of_line, produced))
                    token_beats_due.push_back(produced);
            end
        end
        o_fail_count      <= fail_count;
        o_pending         <= token_beats_due.size();
        o_beats_checked   <= beats_checked;
        o_full_lines      <= full_lines;
        o_truncated_lines <= truncated_lines;
    end

endmodule

FILE: test/command_line_tokenizer_core_tb.sv
// Testbench top for command_line_tokenizer_core: clock, reset, line stimulus and verdict.
// Depends on clt_pkg, the core and clt_token_checker.
`timescale 1ns / 1ps

module command_line_tokenizer_core_tb;
    import clt_pkg::*;

    localparam int MAX_ARGS     = 8;
    localparam int ARG_CAPACITY = 32;
    localparam int PHASE_BEATS  = 250;    // character beats per idling phase
    localparam int SETTLE       = 8;      // idle cycles after the final drain
    localparam int CYCLE_LIMIT  = 300000;

    logic       i_clk;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_ch          = '0;
    logic       i_end_of_line = 1'b0;
    logic       i_out_stall   = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_kind;
    logic [2:0] o_arg_index;
    logic [4:0] o_char_pos;
    logic [7:0] o_char_value;
    logic [3:0] o_arg_count;
    logic       o_truncated;

    int fail_count;
    int pending;
    int beats_checked;
    int full_lines;
    int truncated_lines;

    int gap_pct   = 0;   // chance per cycle that the sender holds off
    int stall_pct = 0;   // chance per cycle that the receiver stalls
    int beats_sent = 0;
    int lines_sent = 0;
    int cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    command_line_tokenizer_core #(
        .MAX_ARGS    (MAX_ARGS),
        .ARG_CAPACITY(ARG_CAPACITY)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_ch         (i_ch),
        .i_end_of_line(i_end_of_line),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_arg_index  (o_arg_index),
        .o_char_pos   (o_char_pos),
        .o_char_value (o_char_value),
        .o_arg_count  (o_arg_count),
        .o_truncated  (o_truncated)
    );

    clt_token_checker #(
        .MAX_ARGS    (MAX_ARGS),
        .ARG_CAPACITY(ARG_CAPACITY)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_ch             (i_ch),
        .i_end_of_line    (i_end_of_line),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_kind           (o_kind),
        .i_arg_index      (o_arg_index),
        .i_char_pos       (o_char_pos),
        .i_char_value     (o_char_value),
        .i_arg_count      (o_arg_count),
        .i_truncated      (o_truncated),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_beats_checked  (beats_checked),
        .o_full_lines     (full_lines),
        .o_truncated_lines(truncated_lines)
    );

    // Receiver side: stall at random, independent of anything the core shows.
    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** command_line_tokenizer_core: FAILED **");
        $finish;
    end

    // One input beat. Optional random gap first, then hold valid and payload until the
    // core takes it (valid high, stall low at an edge). Returns just after that edge.
    task automatic send_beat(input logic [7:0] c, input logic eol);
        while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_ch          <= c;
        i_end_of_line <= eol;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (eol)
            lines_sent++;
        else if (c != NUL_CHAR)
            beats_sent++;
    endtask

    // Sender pauses until every expected result beat has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == SPACE_CHAR);
        return c;
    endfunction

    task automatic send_spaces(input int n);
        repeat (n)
            send_beat(SPACE_CHAR, 1'b0);
    endtask

    // A token; now and then a stray zero byte lands inside it.
    task automatic send_token(input int len);
        repeat (len) begin
            if ($urandom_range(0, 24) == 0)
                send_beat(NUL_CHAR, 1'b0);
            send_beat(word_char(), 1'b0);
        end
    endtask

    // Mostly well-formed lines: 0..10 tokens, short ones with the odd token long enough to
    // hit capacity; past the eighth token the spaces fold into the last argument.
    // About one line in eight is raw noise (any byte, zero and space included).
    task automatic send_line();
        int ntok;
        int len;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 20))
                send_beat(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            send_spaces($urandom_range(0, 2));
            ntok = $urandom_range(0, 10);
            for (int t = 0; t < ntok; t++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36)
                                                  : $urandom_range(1, 6);
                send_token(len);
                if (t != ntok - 1)
                    send_spaces($urandom_range(1, 3));
            end
            send_spaces($urandom_range(0, 2));
        end
        // the character on an end-of-line beat is don't-care; vary it anyway
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin : stimulus
        int gap_of[4];
        int stall_of[4];
        int target;
        gap_of   = '{0, 77, 0, 9};
        stall_of = '{0, 0, 77, 9};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty line straight after reset, zero end-of-line char.
        send_beat(NUL_CHAR, 1'b1);
        // Leading and doubled spaces, extreme byte values, a zero byte that must be ignored.
        send_spaces(2);
        send_beat(8'd1, 1'b0);
        send_beat(8'd255, 1'b0);
        send_beat(NUL_CHAR, 1'b0);
        send_spaces(1);
        send_beat(8'h62, 1'b0);
        send_spaces(2);
        send_beat(8'd255, 1'b1);
        // Argument limit: seven one-letter args, then a last arg that swallows spaces.
        for (int a = 0; a < MAX_ARGS - 1; a++) begin
            send_beat(8'h61 + 8'(a), 1'b0);
            send_spaces(1);
        end
        send_beat(8'h78, 1'b0);
        send_spaces(1);
        send_beat(8'h79, 1'b0);
        send_beat(8'h20, 1'b1);
        drain();

        // Random lines over the idling phases; between phases the sender waits for the
        // core to empty out.
        target = beats_sent;
        for (int p = 0; p < 4; p++) begin
            gap_pct   = gap_of[p];
            stall_pct = stall_of[p];
            target += PHASE_BEATS;
            while (beats_sent < target)
                send_line();
            drain();
        end

        stall_pct = 0;
        drain();
        repeat (SETTLE) @(posedge i_clk);

        $display("Sent %0d character beats over %0d lines under four idling mixes; %0d results checked.",
                 beats_sent, lines_sent, beats_checked);
        $display("Lines at the argument limit: %0d, lines with dropped characters: %0d.",
                 full_lines, truncated_lines);
        if (fail_count == 0 && pending == 0) begin
            $display("** command_line_tokenizer_core: PASSED **");
        end else begin
            $display("** command_line_tokenizer_core: FAILED **");
        end
        $finish;
    end

endmodule

FILE: command_line_tokenizer_core.f
+incdir+src
src/clt_pkg.sv
src/clt_step.sv
src/command_line_tokenizer_core.sv
test/clt_token_checker.sv
test/command_line_tokenizer_core_tb.sv
